[hw/rtl/rlde_pkg.sv]
package rlde_pkg;

	// Saturation point of the run counter
	localparam logic [15:0] MAX_RUN = 16'd65535;

	// Run length decoupling queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// ASCII code of digit zero
	localparam logic [7:0] ASCII_ZERO = 8'h30;

	// Run length held as five BCD digits, digit 4 most significant
	typedef logic [4:0][3:0] bcd_t;

	// One queue entry: a finished run (A), an optional trailing one-byte run (B)
	typedef struct packed {
		logic [7:0] a_sym;
		bcd_t       a_digits;
		logic [2:0] a_ndig;    // digits to emit, 0 for a run of one
		logic       a_ovf;
		logic       b_valid;
		logic [7:0] b_sym;
		logic       eos;       // last byte of this entry closes the stream
	} entry_t;

endpackage

[hw/rtl/rlde_front.sv]
module rlde_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tlast,
	input  logic              fifo_full,
	output logic              push,
	output rlde_pkg::entry_t  entry
);

	logic [7:0]     held_q;
	logic [15:0]    len_q;
	rlde_pkg::bcd_t bcd_q;
	logic           active_q;

	logic           accept;
	logic           same;
	logic [15:0]    ext_len;
	rlde_pkg::bcd_t ext_bcd;

	function automatic rlde_pkg::bcd_t bcd_inc(input rlde_pkg::bcd_t d);
		rlde_pkg::bcd_t r;
		logic           c;
		r = d;
		c = 1'b1;
		for (int i = 0; i < 5; i++) begin
			if (c) begin
				if (d[i] == 4'd9) begin
					r[i] = 4'd0;
				end else begin
					r[i] = d[i] + 4'd1;
					c = 1'b0;
				end
			end
		end
		return r;
	endfunction

	function automatic logic [2:0] ndig(input rlde_pkg::bcd_t d, input logic gt1);
		logic [2:0] n;
		priority if (!gt1)         n = 3'd0;
		else if (d[4] != 4'd0)     n = 3'd5;
		else if (d[3] != 4'd0)     n = 3'd4;
		else if (d[2] != 4'd0)     n = 3'd3;
		else if (d[1] != 4'd0)     n = 3'd2;
		else                       n = 3'd1;
		return n;
	endfunction

	assign s_tready = !fifo_full;
	assign accept   = s_tvalid && s_tready;
	assign same     = active_q && (s_tdata == held_q);
	assign ext_len  = (len_q != rlde_pkg::MAX_RUN) ? len_q + 16'd1 : len_q;
	assign ext_bcd  = (len_q != rlde_pkg::MAX_RUN) ? bcd_inc(bcd_q) : bcd_q;
	assign push     = accept && ((!same && active_q) || s_tlast);

	always_comb begin
		entry         = '0;
		entry.eos     = s_tlast;
		entry.b_sym   = s_tdata;
		if (same) begin
			entry.a_sym    = held_q;
			entry.a_digits = ext_bcd;
			entry.a_ndig   = ndig(ext_bcd, ext_len > 16'd1);
			entry.a_ovf    = (ext_len == rlde_pkg::MAX_RUN);
		end else if (active_q) begin
			entry.a_sym    = held_q;
			entry.a_digits = bcd_q;
			entry.a_ndig   = ndig(bcd_q, len_q > 16'd1);
			entry.a_ovf    = (len_q == rlde_pkg::MAX_RUN);
			entry.b_valid  = s_tlast;
		end else begin
			// lone final byte: a run of one
			entry.a_sym    = s_tdata;
			entry.a_digits = rlde_pkg::bcd_t'(20'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			len_q    <= '0;
			bcd_q    <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				held_q   <= '0;
				len_q    <= '0;
				bcd_q    <= '0;
				active_q <= 1'b0;
			end else if (same) begin
				len_q <= ext_len;
				bcd_q <= ext_bcd;
			end else begin
				held_q   <= s_tdata;
				len_q    <= 16'd1;
				bcd_q    <= rlde_pkg::bcd_t'(20'd1);
				active_q <= 1'b1;
			end
		end
	end

endmodule

[hw/rtl/rlde_fifo.sv]
module rlde_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rlde_pkg::entry_t  wr_entry,
	output logic              full,
	input  logic              pop,
	output rlde_pkg::entry_t  rd_entry,
	output logic              not_empty
);

	rlde_pkg::entry_t                 mem_q [rlde_pkg::FIFO_DEPTH];
	logic [rlde_pkg::FIFO_AW-1:0]     wr_ptr_q;
	logic [rlde_pkg::FIFO_AW-1:0]     rd_ptr_q;
	logic [rlde_pkg::FIFO_CW-1:0]     count_q;

	assign full      = (count_q == rlde_pkg::FIFO_CW'(rlde_pkg::FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + rlde_pkg::FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + rlde_pkg::FIFO_AW'(1);
			end
			count_q <= count_q + rlde_pkg::FIFO_CW'(push) - rlde_pkg::FIFO_CW'(pop);
		end
	end

endmodule

[hw/rtl/rlde_back.sv]
module rlde_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fifo_valid,
	input  rlde_pkg::entry_t  fifo_entry,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,
	output logic              m_tlast,
	output logic              m_tuser
);

	rlde_pkg::entry_t cur_q;
	logic             cur_valid_q;
	logic [2:0]       idx_q;
	logic [15:0]      pos_q;

	logic             m_valid_q;
	logic [23:0]      m_data_q;
	logic             m_last_q;
	logic             m_user_q;

	logic             adv;
	logic             is_last;
	logic [2:0]       last_idx;
	logic [2:0]       sel;
	logic [3:0]       digit;
	logic [7:0]       byte_val;
	logic             ovf_val;
	logic             eos_val;

	assign last_idx = cur_q.a_ndig + 3'(cur_q.b_valid);
	assign is_last  = (idx_q == last_idx);
	assign adv      = cur_valid_q && (!m_valid_q || m_tready);
	assign pop      = fifo_valid && (!cur_valid_q || (adv && is_last));
	assign sel      = cur_q.a_ndig - idx_q;
	assign eos_val  = is_last && cur_q.eos;

	always_comb begin
		unique case (sel)
			3'd0:    digit = cur_q.a_digits[0];
			3'd1:    digit = cur_q.a_digits[1];
			3'd2:    digit = cur_q.a_digits[2];
			3'd3:    digit = cur_q.a_digits[3];
			3'd4:    digit = cur_q.a_digits[4];
			default: digit = 4'd0;
		endcase
	end

	// byte order of an entry: run byte, its digits, then the trailing byte
	always_comb begin
		priority if (idx_q == 3'd0) begin
			byte_val = cur_q.a_sym;
			ovf_val  = cur_q.a_ovf;
		end else if (idx_q <= cur_q.a_ndig) begin
			byte_val = rlde_pkg::ASCII_ZERO | {4'd0, digit};
			ovf_val  = cur_q.a_ovf;
		end else begin
			byte_val = cur_q.b_sym;
			ovf_val  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= fifo_entry;
		end
		if (adv) begin
			m_data_q <= {pos_q, byte_val};
			m_last_q <= eos_val;
			m_user_q <= ovf_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			pos_q       <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (adv) begin
				m_valid_q <= 1'b1;
				pos_q     <= eos_val ? 16'd0 : pos_q + 16'd1;
				if (!is_last) begin
					idx_q <= idx_q + 3'd1;
				end
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			// next entry loads as the last byte of the current one leaves
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (adv && is_last) begin
				cur_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_user_q;

endmodule

[hw/rtl/run_length_decimal_encoder.sv]
// Run-length encoder with ASCII decimal counts.
// Input stream (s_*): one byte symbol per transaction in s_tdata, s_tlast on
//   the last byte of a stream. Output stream (m_*): one compressed byte per
//   transaction. Each run comes out as its symbol, followed by its length in
//   decimal ASCII digits (most significant first) when the length exceeds one.
// m_tdata carries the byte and its index in the compressed stream; m_tlast
//   marks the final byte of a stream, m_tuser flags a run saturated at MAX_RUN.
// Throughput: one input transaction per cycle unless the queue is full, one output byte
//   per cycle while m_tready is high. A run of n bytes never produces more than n output
//   bytes, so a steady stream sustains one byte per cycle; the 4-entry run queue absorbs bursts.
// Path: after the transaction that closes a run, its first byte passes the queue
//   write, the unpack register and the output register before showing on m_tvalid.
// Stall: when m_tready is low a valid byte in the output register holds; the unpacker waits,
//   the queue fills, and s_tready drops once the queue is full.
// Reset: no run held, queue empty, output position zero. After a stream ends
//   (s_tlast) the block returns to that state for the next stream.
module run_length_decimal_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] symbol
	input  logic        s_tlast,   // final_symbol
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] out_position
	output logic        m_tlast,   // end_of_output
	output logic        m_tuser    // [0] run_overflow
);

	logic             push;
	logic             pop;
	logic             fifo_full;
	logic             fifo_valid;
	rlde_pkg::entry_t wr_entry;
	rlde_pkg::entry_t rd_entry;

	// Front: tracks the current run, pushes finished runs into the queue
	rlde_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.fifo_full (fifo_full),
		.push      (push),
		.entry     (wr_entry)
	);

	// Queue between run tracking and byte emission
	rlde_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.full      (fifo_full),
		.pop       (pop),
		.rd_entry  (rd_entry),
		.not_empty (fifo_valid)
	);

	// Back: unpacks each run into bytes, numbers them, drives the output register
	rlde_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_valid (fifo_valid),
		.fifo_entry (rd_entry),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

[tb/sv/tb_run_length_decimal_encoder.sv]
`timescale 1ns / 100ps

// Tracks the compressed stream the encoder should produce and matches the
// bytes it actually produces against it, oldest first.
class rle_stream_tracker;

	typedef struct {
		logic [7:0]  out_val;
		logic [15:0] position;
		logic        eos;
		logic        ovf;
	} coded_byte_t;

	coded_byte_t pending_bytes[$];
	int          errors;

	// mirror of the encoder's run state
	logic [7:0]  held_sym;
	logic [15:0] run_len;
	logic        run_on;
	logic [15:0] wr_pos;

	function new();
		errors = 0;
		clear_stream();
	endfunction

	function void clear_stream();
		held_sym = '0;
		run_len  = '0;
		run_on   = 1'b0;
		wr_pos   = '0;
	endfunction

	function void push_byte(logic [7:0] value, logic ovf);
		coded_byte_t cb;
		cb.out_val  = value;
		cb.position = wr_pos;
		cb.eos      = 1'b0;
		cb.ovf      = ovf;
		pending_bytes.push_back(cb);
		wr_pos = wr_pos + 16'd1;
	endfunction

	// symbol, then the count in ASCII decimal when it exceeds one
	function void push_run(logic [7:0] sym, logic [15:0] len);
		logic [7:0]  digits[$];
		int unsigned v;
		logic        ovf;
		ovf = (len >= rlde_pkg::MAX_RUN);
		v   = len;
		push_byte(sym, ovf);
		if (len > 16'd1) begin
			while (v != 0) begin
				digits.push_front(rlde_pkg::ASCII_ZERO + 8'(v % 10));
				v = v / 10;
			end
			foreach (digits[i])
				push_byte(digits[i], ovf);
		end
	endfunction

	// one accepted input transaction
	function void take_symbol(logic [7:0] sym, logic fin);
		if (run_on && sym == held_sym) begin
			if (run_len < rlde_pkg::MAX_RUN)
				run_len = run_len + 16'd1;
		end else begin
			if (run_on)
				push_run(held_sym, run_len);
			held_sym = sym;
			run_len  = 16'd1;
			run_on   = 1'b1;
		end
		if (fin) begin
			push_run(held_sym, run_len);
			pending_bytes[pending_bytes.size() - 1].eos = 1'b1;
			clear_stream();
		end
	endfunction

	task report(string msg);
		if (errors < 40)
			$display("MISMATCH @%0t: %s", $time, msg);
		errors++;
	endtask

	// one accepted output transaction
	task match_output(logic [7:0] value, logic [15:0] pos, logic eos, logic ovf);
		coded_byte_t cb;
		if (pending_bytes.size() == 0) begin
			report($sformatf("unexpected byte %02h at position %0d", value, pos));
		end else begin
			cb = pending_bytes.pop_front();
			if (value !== cb.out_val)
				report($sformatf("out_byte %02h, want %02h (position %0d)",
					value, cb.out_val, cb.position));
			if (pos !== cb.position)
				report($sformatf("out_position %0d, want %0d", pos, cb.position));
			if (eos !== cb.eos)
				report($sformatf("end_of_output %b, want %b (position %0d)",
					eos, cb.eos, cb.position));
			if (ovf !== cb.ovf)
				report($sformatf("run_overflow %b, want %b (position %0d)",
					ovf, cb.ovf, cb.position));
		end
	endtask

	function int outstanding();
		return pending_bytes.size();
	endfunction

endclass

module tb_run_length_decimal_encoder;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;

	int idle_pct  = 0;
	int stall_pct = 0;
	int symbols_in = 0;

	rle_stream_tracker tracker = new();

	run_length_decimal_encoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// generous bound: the slowest correct run is well under a quarter of this
	initial begin
		#4_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver backpressure
	initial begin
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			tracker.match_output(m_tdata[7:0], m_tdata[23:8], m_tlast, m_tuser);
	end

	// called at a falling edge, returns at a falling edge
	task send_symbol(logic [7:0] sym, logic fin);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= sym;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		tracker.take_symbol(sym, fin);
		symbols_in++;
		@(negedge clk);
	endtask

	task send_run(logic [7:0] sym, int len, logic fin);
		for (int i = 0; i < len; i++)
			send_symbol(sym, fin && (i == len - 1));
	endtask

	// sender holds off until the encoder has delivered everything owed
	task drain_output();
		s_tvalid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(negedge clk);
	endtask

	// a whole stream: a few runs of mostly short length, last byte final
	task send_random_stream();
		int         n_runs;
		int         len;
		int         pick;
		logic [7:0] sym;
		n_runs = $urandom_range(8, 1);
		for (int r = 0; r < n_runs; r++) begin
			pick = $urandom_range(99);
			// a two-letter alphabet makes neighbouring runs merge now and then
			if (pick < 25)
				sym = 8'h41 + 8'($urandom_range(1));
			else
				sym = 8'($urandom);
			pick = $urandom_range(99);
			if (pick < 65)
				len = $urandom_range(3, 1);
			else if (pick < 95)
				len = $urandom_range(15, 4);
			else
				len = $urandom_range(120, 16);
			send_run(sym, len, r == n_runs - 1);
		end
	endtask

	initial begin
		int phase_start;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: lone final bytes at both symbol extremes
		send_symbol(8'h00, 1'b1);
		send_symbol(8'hFF, 1'b1);
		// run of two then a final byte that closes it and stands alone
		send_run(8'h41, 2, 1'b0);
		send_symbol(8'h42, 1'b1);
		// two-digit count with a zero digit
		send_run(8'h00, 10, 1'b0);
		send_symbol(8'hFF, 1'b1);
		// final byte extends the held run
		send_run(8'h7E, 2, 1'b1);
		drain_output();

		// three-digit count with two zero digits, closed by a final byte of its own
		send_run(8'h30, 100, 1'b0);
		send_symbol(8'h31, 1'b1);
		drain_output();

		// random streams under each idling mix
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 54; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 54; end
				default: begin idle_pct = 14; stall_pct = 14; end
			endcase
			phase_start = symbols_in;
			while (symbols_in - phase_start < 75)
				send_random_stream();
			drain_output();
		end

		idle_pct  = 0;
		stall_pct = 0;
		repeat (16) @(negedge clk);
		if (tracker.outstanding() != 0)
			tracker.report($sformatf("%0d bytes never came out", tracker.outstanding()));

		if (tracker.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
